// ----- src/ple_pkg.sv -----
// ple_pkg: command, status and cell-operation codes, and the transaction
// structs of the positional list engine. No dependencies.

package ple_pkg;

	// Command codes; the unused code is ignored and reports the count
	typedef enum logic [2:0] {
		CMD_APPEND   = 3'd0,
		CMD_INSERT   = 3'd1,
		CMD_GET      = 3'd2,
		CMD_SET      = 3'd3,
		CMD_REMOVE   = 3'd4,
		CMD_INDEX_OF = 3'd5,
		CMD_CLEAR    = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_RANGE_ERR = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// Operation broadcast to every cell of the chain
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_WRITE,
		OP_INSERT,
		OP_REMOVE,
		OP_MATCH
	} cell_op_t;

	typedef struct packed {
		cmd_t        command;
		logic [4:0]  position;
		logic [31:0] element;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] read_element;
		logic [3:0]  found_position;
		logic        found;
		logic [4:0]  count;
		logic        empty_res;
	} rsp_t;

endpackage

// ----- src/ple_cell.sv -----
// ple_cell: one storage cell of the list chain. Holds one entry, takes its
// neighbor's entry on insert/remove shifts, and registers a match flag.
// Depends on ple_pkg.

module ple_cell #(
	parameter int IDX = 0,
	parameter int LW  = 5,
	parameter int SW  = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ple_pkg::cell_op_t   op,
	input  logic [LW-1:0]       pos,
	input  logic [LW-1:0]       cnt,
	input  logic [SW-1:0]       elem,
	input  logic [SW-1:0]       left_data,
	input  logic [SW-1:0]       right_data,
	output logic [SW-1:0]       data,
	output logic                match
);
	import ple_pkg::*;

	localparam logic [LW-1:0] MY_IDX = LW'(IDX);

	logic [SW-1:0] data_q;
	logic          match_q;

	// Entry storage: write in place, shift up on insert, shift down on remove
	always_ff @(posedge clk) begin
		unique case (op)
			OP_WRITE: begin
				if (MY_IDX == pos) data_q <= elem;
			end
			OP_INSERT: begin
				if (MY_IDX == pos) data_q <= elem;
				else if (MY_IDX > pos) data_q <= left_data;
			end
			OP_REMOVE: begin
				if (MY_IDX >= pos) data_q <= right_data;
			end
			default: ;
		endcase
	end

	// Match flag, only for occupied positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (op == OP_MATCH) begin
			match_q <= (data_q == elem) && (MY_IDX < cnt);
		end
	end

	assign data  = data_q;
	assign match = match_q;

endmodule

// ----- src/ple_find.sv -----
// ple_find: first-match priority encoder over the registered match flags
// of the cell chain. No dependencies.

module ple_find #(
	parameter int N  = 16,
	parameter int IW = 4
) (
	input  logic [N-1:0]  match,
	output logic          found,
	output logic [IW-1:0] index
);

	// Lowest set flag wins: scan from the top so lower ones overwrite
	always_comb begin
		index = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (match[i]) index = IW'(i);
		end
	end

	assign found = |match;

endmodule

// ----- src/positional_list_engine.sv -----
// positional_list_engine: ordered list of element words held in a chain of
// cells, addressed by position. Depends on ple_pkg, ple_cell, ple_find.
//
// A command is taken at a clock edge where start is high and busy is low.
// Its result appears with done high for exactly one cycle; the receiver cannot
// stall it. Except for index_of, the result comes in the next cycle. Append,
// insert, get, set, remove and clear never raise busy, so they may be issued
// every cycle: every cell shifts or writes in parallel. For index_of the cells
// register their compare flags first and the first-match encoder then resolves
// them into the result, with busy high in between. Entry contents and the result
// payload come out of reset undefined; count, busy, done and match flags are reset.

module positional_list_engine #(
	parameter int CAPACITY      = 16,
	parameter int ELEMENT_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ple_pkg::req_t req,
	output logic          done,
	output ple_pkg::rsp_t rsp
);
	import ple_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = (CW > 5) ? CW : 5;
	localparam int IW = $clog2(CAPACITY);
	localparam int SW = (ELEMENT_WIDTH < 32) ? ELEMENT_WIDTH : 32;

	logic [CW-1:0] count_q;
	logic          busy_q;
	logic          done_q;
	rsp_t          rsp_q;

	logic          accept;
	logic [LW-1:0] pos_ext;
	logic [LW-1:0] cnt_ext;
	logic [SW-1:0] elem_in;
	logic          full;

	cell_op_t      op;
	logic [LW-1:0] wpos;
	status_t       status;
	logic          rd_en;
	logic          search;
	logic [CW-1:0] cnt_next;

	logic [SW-1:0]       cell_data [CAPACITY];
	logic [CAPACITY-1:0] cell_match;
	logic [SW-1:0]       rd_word;
	logic                find_hit;
	logic [IW-1:0]       find_idx;

	assign accept  = start && !busy_q;
	assign pos_ext = LW'(req.position);
	assign cnt_ext = LW'(count_q);
	assign elem_in = req.element[SW-1:0];
	assign full    = cnt_ext >= LW'(CAPACITY);

	// Command decode: checks, cell operation and next count
	always_comb begin
		op       = OP_HOLD;
		wpos     = pos_ext;
		status   = ST_OK;
		rd_en    = 1'b0;
		search   = 1'b0;
		cnt_next = count_q;
		if (accept) begin
			unique case (req.command)
				CMD_APPEND: begin
					if (full) begin
						status = ST_FULL;
					end else begin
						op       = OP_WRITE;
						wpos     = cnt_ext;
						cnt_next = count_q + CW'(1);
					end
				end
				CMD_INSERT: begin
					if (pos_ext > cnt_ext) begin
						status = ST_RANGE_ERR;
					end else if (full) begin
						status = ST_FULL;
					end else begin
						op       = OP_INSERT;
						cnt_next = count_q + CW'(1);
					end
				end
				CMD_GET: begin
					if (pos_ext >= cnt_ext) status = ST_RANGE_ERR;
					else rd_en = 1'b1;
				end
				CMD_SET: begin
					if (pos_ext >= cnt_ext) status = ST_RANGE_ERR;
					else op = OP_WRITE;
				end
				CMD_REMOVE: begin
					if (pos_ext >= cnt_ext) begin
						status = ST_RANGE_ERR;
					end else begin
						op       = OP_REMOVE;
						rd_en    = 1'b1;
						cnt_next = count_q - CW'(1);
					end
				end
				CMD_INDEX_OF: begin
					op     = OP_MATCH;
					search = 1'b1;
				end
				CMD_CLEAR: begin
					cnt_next = '0;
				end
				default: ;
			endcase
		end
	end

	// Cell chain; the ends take zero from outside
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [SW-1:0] left_w;
		logic [SW-1:0] right_w;
		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[g+1];
		end
		ple_cell #(
			.IDX (g),
			.LW  (LW),
			.SW  (SW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.pos        (wpos),
			.cnt        (cnt_ext),
			.elem       (elem_in),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (cell_data[g]),
			.match      (cell_match[g])
		);
	end

	// Read port for get and remove
	assign rd_word = cell_data[pos_ext[IW-1:0]];

	ple_find #(
		.N  (CAPACITY),
		.IW (IW)
	) u_find (
		.match (cell_match),
		.found (find_hit),
		.index (find_idx)
	);

	// Control: count, search pending, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			count_q <= cnt_next;
			if (busy_q) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				busy_q <= accept && search;
				done_q <= accept && !search;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (busy_q) begin
			rsp_q.status         <= ST_OK;
			rsp_q.read_element   <= '0;
			rsp_q.found          <= find_hit;
			rsp_q.found_position <= find_hit ? 4'(find_idx) : 4'd0;
			rsp_q.count          <= 5'(count_q);
			rsp_q.empty_res      <= (count_q == '0);
		end else if (accept) begin
			rsp_q.status         <= status;
			rsp_q.read_element   <= rd_en ? 32'(rd_word) : 32'd0;
			rsp_q.found          <= 1'b0;
			rsp_q.found_position <= 4'd0;
			rsp_q.count          <= 5'(cnt_next);
			rsp_q.empty_res      <= (cnt_next == '0);
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ----- dv/ple_result_check.sv -----
`timescale 1ns / 100ps
// ple_result_check: watches the command and result channels of the positional
// list engine, keeps its own copy of the list and compares every result.
// Depends on ple_pkg.

module ple_result_check (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  ple_pkg::req_t  req,
	input  logic           done,
	input  ple_pkg::rsp_t  rsp,
	output int             errors,
	output int             pending
);
	import ple_pkg::*;

	localparam int LIST_CAPACITY = 16;

	// Shadow list and the results still owed by the engine
	logic [31:0] shadow_words [LIST_CAPACITY];
	int          shadow_len;
	rsp_t        owed_rsp [$];
	rsp_t        want;
	int          fail_tally;

	// Apply one command to the shadow list and return the result it causes
	function automatic rsp_t apply_command(req_t cmd_in);
		rsp_t res;
		int   pos;
		int   i;
		res = '0;
		pos = cmd_in.position;
		case (cmd_in.command)
			CMD_APPEND: begin
				if (shadow_len >= LIST_CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					shadow_words[shadow_len] = cmd_in.element;
					shadow_len++;
				end
			end
			CMD_INSERT: begin
				// position check wins over the full check
				if (pos > shadow_len) begin
					res.status = ST_RANGE_ERR;
				end else if (shadow_len >= LIST_CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					for (i = shadow_len; i > pos; i--)
						shadow_words[i] = shadow_words[i - 1];
					shadow_words[pos] = cmd_in.element;
					shadow_len++;
				end
			end
			CMD_GET: begin
				if (pos >= shadow_len)
					res.status = ST_RANGE_ERR;
				else
					res.read_element = shadow_words[pos];
			end
			CMD_SET: begin
				if (pos >= shadow_len)
					res.status = ST_RANGE_ERR;
				else
					shadow_words[pos] = cmd_in.element;
			end
			CMD_REMOVE: begin
				if (pos >= shadow_len) begin
					res.status = ST_RANGE_ERR;
				end else begin
					res.read_element = shadow_words[pos];
					for (i = pos; i + 1 < shadow_len; i++)
						shadow_words[i] = shadow_words[i + 1];
					shadow_len--;
				end
			end
			CMD_INDEX_OF: begin
				// first match only
				for (i = shadow_len - 1; i >= 0; i--) begin
					if (shadow_words[i] == cmd_in.element) begin
						res.found_position = i[3:0];
						res.found          = 1'b1;
					end
				end
			end
			CMD_CLEAR: begin
				shadow_len = 0;
			end
			default: begin
				// unused code: no change, count reported
			end
		endcase
		res.count     = shadow_len[4:0];
		res.empty_res = (shadow_len == 0);
		return res;
	endfunction

	// Compare finished transactions, then record newly accepted ones
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_len = 0;
			owed_rsp.delete();
			fail_tally = 0;
			errors     <= 0;
			pending    <= 0;
		end else begin
			if (done) begin
				if (owed_rsp.size() == 0) begin
					$display("%0t: result with no command outstanding: %p", $time, rsp);
					fail_tally++;
				end else begin
					want = owed_rsp.pop_front();
					if (rsp.status !== want.status) begin
						$display("%0t: status expected %0d, got %0d",
							$time, want.status, rsp.status);
						fail_tally++;
					end
					if (rsp.read_element !== want.read_element) begin
						$display("%0t: read_element expected %h, got %h",
							$time, want.read_element, rsp.read_element);
						fail_tally++;
					end
					if (rsp.found_position !== want.found_position) begin
						$display("%0t: found_position expected %0d, got %0d",
							$time, want.found_position, rsp.found_position);
						fail_tally++;
					end
					if (rsp.found !== want.found) begin
						$display("%0t: found expected %b, got %b",
							$time, want.found, rsp.found);
						fail_tally++;
					end
					if (rsp.count !== want.count) begin
						$display("%0t: count expected %0d, got %0d",
							$time, want.count, rsp.count);
						fail_tally++;
					end
					if (rsp.empty_res !== want.empty_res) begin
						$display("%0t: empty_res expected %b, got %b",
							$time, want.empty_res, rsp.empty_res);
						fail_tally++;
					end
				end
			end
			if (start && !busy)
				owed_rsp.push_back(apply_command(req));
			errors  <= fail_tally;
			pending <= owed_rsp.size();
		end
	end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// testbench: drives directed and random list commands into the positional
// list engine and gives the verdict. Depends on ple_pkg,
// positional_list_engine and ple_result_check.

module testbench;
	import ple_pkg::*;

	localparam logic [2:0] CMD_UNUSED   = 3'd7;
	localparam int         RANDOM_ITEMS = 1250;
	localparam int         MAX_GAP      = 18;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;
	int   chk_errors;
	int   chk_pending;

	// Stimulus shaping only: list length as the stimulus expects it
	int   depth_est;
	bit   no_idle;
	bit   grow;

	positional_list_engine uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	ple_result_check result_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.rsp     (rsp),
		.errors  (chk_errors),
		.pending (chk_pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	// Send one transaction; called and returns at a falling edge
	task automatic issue(input cmd_t cmd, input int pos, input logic [31:0] word);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start        <= 1'b1;
		req.command  <= cmd;
		req.position <= pos[4:0];
		req.element  <= word;
		#1;
		while (busy) begin
			@(negedge clk);
			#1;
		end
		@(posedge clk);
		@(negedge clk);
		case (cmd)
			CMD_APPEND:
				if (depth_est < 16) depth_est++;
			CMD_INSERT:
				if (pos <= depth_est && depth_est < 16) depth_est++;
			CMD_REMOVE:
				if (pos < depth_est) depth_est--;
			CMD_CLEAR:
				depth_est = 0;
			default: ;
		endcase
	endtask

	// Hold off until every owed result has come back
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (chk_pending != 0) @(negedge clk);
	endtask

	// Element words: a small pool gives search hits and duplicates
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 5))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			2, 3:    return 32'hA5A5_0000 | $urandom_range(0, 5);
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_pos();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return $urandom_range(0, depth_est);
		else if (r < 9)
			return $urandom_range(0, 16);
		else
			return $urandom_range(0, 31);
	endfunction

	initial begin
		int   sent;
		int   r;
		int   phase_left;
		int   idle_left;
		cmd_t cmd;
		arst_n    = 1'b0;
		start     = 1'b0;
		req       = '0;
		depth_est = 0;
		no_idle   = 1'b0;
		grow      = 1'b1;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty list errors, fill to full, full and range errors
		issue(CMD_GET, 0, 32'h0);
		issue(CMD_REMOVE, 0, 32'h0);
		issue(CMD_SET, 0, 32'hFFFF_FFFF);
		issue(CMD_INDEX_OF, 0, 32'h0);
		issue(CMD_INSERT, 1, 32'h5);
		issue(CMD_INSERT, 0, 32'hFFFF_FFFF);
		issue(CMD_APPEND, 31, 32'h0);
		for (int i = 0; i < 14; i++)
			issue((i % 2) ? CMD_APPEND : CMD_INSERT, i % 3, 32'h1234_0000 + (i % 5));
		issue(CMD_APPEND, 0, 32'h1);
		issue(CMD_INSERT, 16, 32'h1);
		issue(CMD_INSERT, 17, 32'h1);
		issue(CMD_SET, 15, 32'hC0DE_0001);
		issue(CMD_INDEX_OF, 0, 32'hC0DE_0001);
		issue(CMD_INDEX_OF, 0, 32'h1234_0002);
		issue(CMD_GET, 15, 32'h0);
		issue(CMD_REMOVE, 0, 32'h0);
		issue(CMD_REMOVE, 15, 32'h0);
		issue(cmd_t'(CMD_UNUSED), 31, 32'hFFFF_FFFF);
		issue(CMD_CLEAR, 0, 32'h0);
		issue(CMD_GET, 0, 32'h0);
		drain();

		// Random: alternating grow and shrink phases, bursts without idling
		sent       = 0;
		phase_left = $urandom_range(20, 60);
		idle_left  = $urandom_range(20, 60);
		while (sent < RANDOM_ITEMS) begin
			if (--phase_left == 0) begin
				grow       = !grow;
				phase_left = $urandom_range(20, 60);
			end
			if (--idle_left == 0) begin
				no_idle   = ($urandom_range(0, 2) == 0);
				idle_left = $urandom_range(20, 60);
			end
			r = $urandom_range(0, 99);
			if (r < (grow ? 30 : 10))
				cmd = CMD_APPEND;
			else if (r < (grow ? 50 : 20))
				cmd = CMD_INSERT;
			else if (r < (grow ? 60 : 35))
				cmd = CMD_GET;
			else if (r < (grow ? 70 : 45))
				cmd = CMD_SET;
			else if (r < (grow ? 80 : 75))
				cmd = CMD_REMOVE;
			else if (r < 98)
				cmd = CMD_INDEX_OF;
			else if (r == 98)
				cmd = CMD_CLEAR;
			else
				cmd = cmd_t'(CMD_UNUSED);
			issue(cmd, pick_pos(), pick_word());
			if (cmd != cmd_t'(CMD_UNUSED))
				sent++;
			if ($urandom_range(0, 99) == 0)
				drain();
		end

		// Wind down: all results in, then wait quietly for strays
		drain();
		repeat (4) @(negedge clk);
		if (chk_errors == 0 && chk_pending == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
